// ----- src/scancode_to_ascii_key_fifo_top_macros.svh -----
// Assertion macros for the key ring RTL.
`ifndef SCANCODE_TO_ASCII_KEY_FIFO_TOP_MACROS_SVH
`define SCANCODE_TO_ASCII_KEY_FIFO_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset.
`define SC2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define SC2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SC2A_ASSERT(lbl, prop, msg)
`define SC2A_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/sc2a_pkg.sv -----
// Package with constants, action codes and the set-1 translation table.
`timescale 1ns / 1ps
package sc2a_pkg;

  localparam int unsigned CODE_W      = 8;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned RELEASE_BIT = 7;

  localparam logic ACT_SCAN = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NONE = 7'h00;
  localparam logic [CHAR_W-1:0] CH_BS   = 7'h08;
  localparam logic [CHAR_W-1:0] CH_TAB  = 7'h09;
  localparam logic [CHAR_W-1:0] CH_LF   = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_ESC  = 7'h1B;

  // US layout, scancode set 1, make codes only; zero means "no character".
  function automatic logic [CHAR_W-1:0] set1_lookup(input logic [CODE_W-2:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CH_NONE;
    unique case (code)
      7'h01: ch = CH_ESC;
      7'h02: ch = 7'h31;  // 1
      7'h03: ch = 7'h32;
      7'h04: ch = 7'h33;
      7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;
      7'h07: ch = 7'h36;
      7'h08: ch = 7'h37;
      7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;
      7'h0B: ch = 7'h30;  // 0
      7'h0C: ch = 7'h2D;  // -
      7'h0D: ch = 7'h3D;  // =
      7'h0E: ch = CH_BS;
      7'h0F: ch = CH_TAB;
      7'h10: ch = 7'h71;  // q
      7'h11: ch = 7'h77;
      7'h12: ch = 7'h65;
      7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;
      7'h15: ch = 7'h79;
      7'h16: ch = 7'h75;
      7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;
      7'h19: ch = 7'h70;  // p
      7'h1A: ch = 7'h5B;  // [
      7'h1B: ch = 7'h5D;  // ]
      7'h1C: ch = CH_LF;
      7'h1E: ch = 7'h61;  // a
      7'h1F: ch = 7'h73;
      7'h20: ch = 7'h64;
      7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;
      7'h23: ch = 7'h68;
      7'h24: ch = 7'h6A;
      7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;  // l
      7'h27: ch = 7'h3B;  // ;
      7'h28: ch = 7'h27;  // apostrophe
      7'h29: ch = 7'h60;  // backtick
      7'h2B: ch = 7'h5C;  // backslash
      7'h2C: ch = 7'h7A;  // z
      7'h2D: ch = 7'h78;
      7'h2E: ch = 7'h63;
      7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;
      7'h31: ch = 7'h6E;
      7'h32: ch = 7'h6D;  // m
      7'h33: ch = 7'h2C;  // ,
      7'h34: ch = 7'h2E;  // .
      7'h35: ch = 7'h2F;  // /
      7'h37: ch = 7'h2A;  // keypad *
      7'h39: ch = 7'h20;  // space
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ----- src/scancode_to_ascii_key_fifo_top.sv -----
// Top level: set-1 scancode translator feeding a character ring with pop on request.
`timescale 1ns / 1ps
// Results: a scancode beat yields its (zero) result beat in the cycle after acceptance; a read
//   beat that pops passes the RAM read register and ST_READ before the result register.
// Rate: one beat per cycle for scancodes and empty reads while the result is not stalled; no
//   new beat is taken during a pop, set by the registered read port of the character RAM.
// Reset clears the pointers, the state machine and the output valid; the RAM keeps its
//   contents, which is safe because only written slots are ever read.
`include "scancode_to_ascii_key_fifo_top_macros.svh"

module scancode_to_ascii_key_fifo_top
  import sc2a_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] scan_code
  input  logic       s_axis_tuser_i,   // [0] action (0 = scancode, 1 = read)
  // Result stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [6:0] character, [7] zero
);

  localparam int unsigned AW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;

  logic              accept;
  logic              out_take;
  logic              is_make;
  logic [CHAR_W-1:0] mapped;
  logic [AW-1:0]     wr_nxt;
  logic              full;
  logic              empty;
  logic              wr_en;
  logic              rd_en;
  logic [CHAR_W-1:0] ram_rdata;

  // Wrap a ring pointer at DEPTH, which need not be a power of two.
  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Take a new beat only between pops and only when the result register is free
  // or drains in this cycle.
  assign out_take        = out_valid_q & m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) & (~out_valid_q | m_axis_tready_i);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;

  // Translate: drop release codes and codes without a character.
  assign is_make = ~s_axis_tdata_i[RELEASE_BIT];
  assign mapped  = set1_lookup(s_axis_tdata_i[CODE_W-2:0]);

  // One slot always stays empty, so equal pointers mean empty.
  assign wr_nxt = advance(wr_ptr_q);
  assign full   = (wr_nxt == rd_ptr_q);
  assign empty  = (wr_ptr_q == rd_ptr_q);

  assign wr_en = accept & (s_axis_tuser_i == ACT_SCAN) & is_make & (mapped != CH_NONE) & ~full;
  assign rd_en = accept & (s_axis_tuser_i == ACT_READ) & ~empty;

  // Pushes and pops never share a cycle, so no forwarding path is needed.
  sc2a_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_ptr_q),
    .wdata_i (mapped),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    wr_ptr_d    = wr_en ? wr_nxt : wr_ptr_q;
    rd_ptr_d    = rd_en ? advance(rd_ptr_q) : rd_ptr_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    state_d     = state_q;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    // Scancodes and empty reads answer at once with a zero character.
    if (accept && !rd_en) begin
      out_valid_d = 1'b1;
      out_char_d  = CH_NONE;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (rd_en) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        // RAM data is ready now; load the popped character.
        out_valid_d = 1'b1;
        out_char_d  = ram_rdata;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};

  `SC2A_ASSERT(a_read_slot_free, (state_q == ST_READ) |-> !out_valid_q, "pop with busy output")
  `SC2A_ASSERT_NEXT(a_accept_answers, accept, (state_q == ST_READ) || out_valid_q, "no result")
  `SC2A_ASSERT_NEXT(a_push_nonempty, wr_en, wr_ptr_q != rd_ptr_q, "ring empty after push")
  `SC2A_ASSERT(a_pop_nonempty, rd_en |-> (wr_ptr_q != rd_ptr_q), "pop from empty ring")

endmodule

// ----- src/sc2a_ram.sv -----
// Character store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module sc2a_ram
  import sc2a_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [CHAR_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [CHAR_W-1:0]        rdata_o
);

  logic [CHAR_W-1:0] mem [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sim/scancode_to_ascii_key_fifo_top_tb.sv -----
// Self-checking bench for the scancode-to-ASCII key ring: table-driven then random beats.
`timescale 1ns / 1ps

module scancode_to_ascii_key_fifo_top_tb;
  import sc2a_pkg::*;

  localparam int unsigned RING_DEPTH   = 256;
  localparam int unsigned RAND_ITEMS   = 1350;
  localparam int unsigned PHASE_ITEMS  = 450;   // items per idling phase
  localparam int unsigned BLOCK_ITEMS  = 225;   // items per traffic block
  localparam int unsigned MAX_GAP      = 8;
  localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no beat on either side
  localparam int unsigned DRAIN_CYCLES = 6;     // idle cycles after the last owed character
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_ROWS     = 25;

  // Traffic mix of one random block.
  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BLEND
  } traffic_mix_e;

  // One row of the directed table; has_fixed marks a result typed in by hand.
  typedef struct packed {
    logic              act;
    logic [7:0]        code;
    logic              has_fixed;
    logic [CHAR_W-1:0] fixed_char;
  } stim_row_t;

  // US set-1 make codes 0x00..0x3F; every code from 0x40 up has no character.
  localparam logic [CHAR_W-1:0] MAKE_TO_ASCII [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Directed rows: empty read after reset, release and unmapped codes, the
  // control characters, a drain down to empty, then a short refill.
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    '{ACT_READ, 8'h00, 1'b1, CH_NONE},  // read on an empty ring
    '{ACT_SCAN, 8'h00, 1'b1, CH_NONE},  // code 0 has no character
    '{ACT_SCAN, 8'hFF, 1'b1, CH_NONE},  // release, all bits set
    '{ACT_SCAN, 8'h80, 1'b1, CH_NONE},  // release of code 0
    '{ACT_SCAN, 8'h7F, 1'b1, CH_NONE},  // highest make code, unmapped
    '{ACT_SCAN, 8'h1D, 1'b1, CH_NONE},  // ctrl modifier, unmapped
    '{ACT_SCAN, 8'h01, 1'b1, CH_NONE},  // escape
    '{ACT_SCAN, 8'h0E, 1'b1, CH_NONE},  // backspace
    '{ACT_SCAN, 8'h0F, 1'b1, CH_NONE},  // tab
    '{ACT_SCAN, 8'h1C, 1'b1, CH_NONE},  // enter
    '{ACT_SCAN, 8'h39, 1'b1, CH_NONE},  // space
    '{ACT_SCAN, 8'h9E, 1'b1, CH_NONE},  // release of a mapped key
    '{ACT_SCAN, 8'h10, 1'b1, CH_NONE},  // q
    '{ACT_READ, 8'hFF, 1'b0, CH_NONE},  // scan byte is don't-care on reads
    '{ACT_READ, 8'h00, 1'b0, CH_NONE},
    '{ACT_READ, 8'h55, 1'b0, CH_NONE},
    '{ACT_READ, 8'hAA, 1'b0, CH_NONE},
    '{ACT_READ, 8'h00, 1'b0, CH_NONE},
    '{ACT_READ, 8'h00, 1'b0, CH_NONE},
    '{ACT_READ, 8'h00, 1'b1, CH_NONE},  // drained back to empty
    '{ACT_SCAN, 8'h35, 1'b1, CH_NONE},  // slash
    '{ACT_SCAN, 8'h37, 1'b1, CH_NONE},  // keypad star
    '{ACT_SCAN, 8'h2B, 1'b1, CH_NONE},  // backslash
    '{ACT_READ, 8'h00, 1'b0, CH_NONE},
    '{ACT_READ, 8'h00, 1'b0, CH_NONE}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // [7:0] scan_code
  logic       s_axis_tuser_i;   // [0] action (0 = scancode, 1 = read)
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // [6:0] character, [7] zero

  // Shadow of the ring: storage and both pointers.
  logic [CHAR_W-1:0] key_ring [RING_DEPTH];
  int unsigned       wr_idx;
  int unsigned       rd_idx;

  // Characters the block still owes on its result stream, oldest first.
  logic [CHAR_W-1:0] owed_chars_q [$];

  int unsigned mismatches;
  int unsigned stall_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  scancode_to_ascii_key_fifo_top #(
    .DEPTH(RING_DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Advance the shadow ring by one accepted beat and return the character
  // the block must answer with.
  function automatic logic [CHAR_W-1:0] key_ring_step(input logic act, input logic [7:0] code);
    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] popped;
    int unsigned       nxt;
    popped = CH_NONE;
    if (act == ACT_SCAN) begin
      // Drop release codes; look up make codes, upper half of the table is empty.
      if (!code[RELEASE_BIT]) begin
        ch = code[6] ? CH_NONE : MAKE_TO_ASCII[code[5:0]];
        if (ch != CH_NONE) begin
          nxt = (wr_idx + 1) % RING_DEPTH;
          // Keep one slot free; a full ring drops the character.
          if (nxt != rd_idx) begin
            key_ring[wr_idx] = ch;
            wr_idx = nxt;
          end
        end
      end
    end else if (wr_idx != rd_idx) begin
      popped = key_ring[rd_idx];
      rd_idx = (rd_idx + 1) % RING_DEPTH;
    end
    return popped;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected 0x%02h, got 0x%02h", $realtime, what, exp_v, act_v);
  endtask

  // Present one beat, hold it until the block takes it, record the owed
  // character, then idle for a random gap per the current sender setting.
  task automatic drive_beat(input logic act, input logic [7:0] code,
                            input logic has_fixed, input logic [CHAR_W-1:0] fixed_char);
    logic [CHAR_W-1:0] predicted;
    int unsigned       gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= code;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    // Beat taken at this edge; the shadow always advances, even for typed rows.
    predicted = key_ring_step(act, code);
    owed_chars_q.push_back(has_fixed ? fixed_char : predicted);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and hold off until every owed character has come back.
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (owed_chars_q.size() != 0) @(posedge clk_i);
  endtask

  // Mostly make codes from the populated part of the table, plus releases
  // and fully random bytes so that every bit of the scan byte toggles.
  function automatic logic [7:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(8'h01, 8'h39));
    if (r < 90) return 8'h80 | 8'($urandom_range(0, 127));
    return 8'($urandom_range(0, 255));
  endfunction

  // Receiver side: drop tready at random per the current setting.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker: compare each result beat with the oldest owed character.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (owed_chars_q.size() == 0) begin
        note_mismatch("unexpected result beat", 8'h00, m_axis_tdata_o);
      end else if (m_axis_tdata_o != {1'b0, owed_chars_q[0]}) begin
        note_mismatch("character", {1'b0, owed_chars_q[0]}, m_axis_tdata_o);
        void'(owed_chars_q.pop_front());
      end else begin
        void'(owed_chars_q.pop_front());
      end
    end
  end

  // Watchdog: end the run if neither stream moves a beat for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    traffic_mix_e mix;
    logic         act;
    int unsigned  read_pct;

    // Drive every input to a known value before the first edge.
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tuser_i  <= ACT_SCAN;
    m_axis_tready_i <= 1'b0;
    mismatches    = 0;
    wr_idx        = 0;
    rd_idx        = 0;
    send_idle_pct = 31;
    recv_idle_pct = 81;
    for (int i = 0; i < RING_DEPTH; i++) key_ring[i] = CH_NONE;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (int r = 0; r < NUM_ROWS; r++)
      drive_beat(STIM_ROWS[r].act, STIM_ROWS[r].code, STIM_ROWS[r].has_fixed,
                 STIM_ROWS[r].fixed_char);
    hold_until_drained();

    // Random part: blocks of fill, blend and drain traffic so the ring runs
    // all the way to full and back to empty.
    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        if (i != 0) hold_until_drained();
        case (i / PHASE_ITEMS)
          0: begin
            send_idle_pct = 31;
            recv_idle_pct = 81;
          end
          1: begin
            send_idle_pct = 81;
            recv_idle_pct = 31;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
      end
      case ((i / BLOCK_ITEMS) % 6) inside
        0, 1:    mix = MIX_FILL;
        3, 4:    mix = MIX_DRAIN;
        default: mix = MIX_BLEND;
      endcase
      case (mix)
        MIX_FILL:  read_pct = 3;
        MIX_DRAIN: read_pct = 85;
        default:   read_pct = 50;
      endcase
      act = ($urandom_range(0, 99) < read_pct) ? ACT_READ : ACT_SCAN;
      drive_beat(act, pick_code(), 1'b0, CH_NONE);
    end

    // Wind down: let the block settle after the last owed character.
    s_axis_tvalid_i <= 1'b0;
    while (owed_chars_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
